// File: hw/rtl/chu_pkg.sv
`default_nettype none

package chu_pkg;

	localparam int WIN_DEPTH = 7;
	localparam logic [11:0] LINE_SAMPLES_RST = 12'd360;

	// register select, taken from the word address
	typedef enum logic {
		REG_MODE = 1'b0,
		REG_LINE = 1'b1
	} reg_sel_t;

	typedef logic [WIN_DEPTH-1:0][7:0] win_t;

	// one pending group of pairs; j counts back from the oldest pair to the newest
	typedef struct packed {
		win_t       win;
		logic [2:0] pmin;
		logic [1:0] j;
		logic       fin;
	} job_t;

	typedef struct packed {
		logic [7:0] even;
		logic [7:0] odd;
		logic       last;
	} pair_t;

endpackage

`default_nettype wire

// File: hw/rtl/chu_cfg.sv
`default_nettype none

module chu_cfg import chu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic             mode,
	output logic [11:0]      line_samples
);

	logic        mode_q;
	logic [11:0] line_samples_q;
	logic        wr_en;
	reg_sel_t    sel;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign sel    = reg_sel_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= 1'b1;
			line_samples_q <= LINE_SAMPLES_RST;
		end else if (wr_en) begin
			unique case (sel)
				REG_MODE: mode_q         <= pwdata[0];
				REG_LINE: line_samples_q <= pwdata[11:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_MODE: prdata = {31'd0, mode_q};
			REG_LINE: prdata = {20'd0, line_samples_q};
			default:  prdata = 32'd0;
		endcase
	end

	assign mode         = mode_q;
	assign line_samples = line_samples_q;

endmodule

`default_nettype wire

// File: hw/rtl/chu_front.sv
`default_nettype none

module chu_front import chu_pkg::*; #(
	parameter int MAX_LINE = 2048
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  chroma_in,
	input  wire logic [11:0] line_samples,
	input  wire logic        emit,
	output logic             job_valid,
	output job_t             job
);

	localparam int PW = $clog2(MAX_LINE);
	localparam int CW = ((PW >= 12) ? PW : 12) + 1;

	win_t          win_q;
	win_t          win_next;
	logic [PW-1:0] pos_q;
	logic [CW-1:0] pos_ext;
	logic [CW-1:0] ls_ext;
	logic [CW-1:0] len;
	logic          line_last;
	logic          has_pair;
	logic          done;
	logic          accept;
	logic          job_v_s1;
	job_t          job_s1;

	assign pos_ext  = CW'(pos_q);
	assign ls_ext   = CW'(line_samples);
	assign win_next = {win_q[WIN_DEPTH-2:0], chroma_in};

	always_comb begin
		if (ls_ext == '0)
			len = CW'(1);
		else if (ls_ext > CW'(MAX_LINE))
			len = CW'(MAX_LINE);
		else
			len = ls_ext;
	end

	assign line_last = (pos_ext + CW'(1)) >= len;
	assign has_pair  = (pos_ext >= CW'(3)) || line_last;

	// a held group is finished when its newest pair goes out
	assign done     = !job_s1.fin || (job_s1.j == 2'd0);
	assign in_stall = job_v_s1 && !(emit && done);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			pos_q <= '0;
		end else if (accept) begin
			win_q <= win_next;
			pos_q <= line_last ? '0 : PW'(pos_ext + CW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			job_v_s1 <= 1'b0;
		else if (accept)
			job_v_s1 <= has_pair;
		else if (emit && done)
			job_v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1.win  <= win_next;
			job_s1.pmin <= (pos_ext >= CW'(7)) ? 3'd7 : pos_ext[2:0];
			job_s1.j    <= (pos_ext >= CW'(3)) ? 2'd3 : pos_ext[1:0];
			job_s1.fin  <= line_last;
		end else if (emit && !done) begin
			job_s1.j <= job_s1.j - 2'd1;
		end
	end

	assign job_valid = job_v_s1;
	assign job       = job_s1;

endmodule

`default_nettype wire

// File: hw/rtl/chu_filter.sv
`default_nettype none

module chu_filter import chu_pkg::*; (
	input  wire logic mode,
	input  wire job_t job,
	output pair_t     pair
);

	localparam logic signed [19:0] C5   = 20'sd5;
	localparam logic signed [19:0] C11  = 20'sd11;
	localparam logic signed [19:0] C21  = 20'sd21;
	localparam logic signed [19:0] C37  = 20'sd37;
	localparam logic signed [19:0] C52  = 20'sd52;
	localparam logic signed [19:0] C70  = 20'sd70;
	localparam logic signed [19:0] C159 = 20'sd159;
	localparam logic signed [19:0] C228 = 20'sd228;
	localparam logic signed [19:0] RND  = 20'sd128;

	logic signed [19:0] t [WIN_DEPTH];
	logic signed [19:0] sum_m2;
	logic signed [19:0] sum_ev;
	logic signed [19:0] sum_od;

	// tap at offset o-3 from pair index; window distance clamped to the line edges
	function automatic logic [7:0] tap_sel(win_t win, logic [2:0] pmin, logic [1:0] j,
			logic [2:0] o);
		logic [3:0] e;
		logic [3:0] dv;
		logic [2:0] d;
		e  = {2'b00, j} + 4'd6 - {1'b0, o};
		dv = e - 4'd3;
		if (e < 4'd3)
			d = 3'd0;
		else if (dv > {1'b0, pmin})
			d = pmin;
		else
			d = dv[2:0];
		return win[d];
	endfunction

	function automatic logic [7:0] round_clip(logic signed [19:0] s);
		logic signed [19:0] v;
		v = s + RND;
		if (v[19])
			return 8'd0;
		else if (v[18:16] != 3'd0)
			return 8'd255;
		else
			return v[15:8];
	endfunction

	always_comb begin
		for (int k = 0; k < WIN_DEPTH; k++)
			t[k] = $signed({12'd0, tap_sel(job.win, job.pmin, job.j, 3'(k))});
		sum_m2 = C21 * (t[1] + t[6]) - C52 * (t[2] + t[5]) + C159 * (t[3] + t[4]);
		sum_ev = C5 * t[0] - C21 * t[1] + C70 * t[2] + C228 * t[3]
			- C37 * t[4] + C11 * t[5];
		sum_od = C5 * t[6] - C21 * t[5] + C70 * t[4] + C228 * t[3]
			- C37 * t[2] + C11 * t[1];
	end

	assign pair.even = mode ? t[3][7:0] : round_clip(sum_ev);
	assign pair.odd  = mode ? round_clip(sum_m2) : round_clip(sum_od);
	assign pair.last = job.fin && (job.j == 2'd0);

endmodule

`default_nettype wire

// File: hw/rtl/chroma_horizontal_upsampler_unit.sv
// a pair is held in the front-end job register and then in the output register after the sample that releases it
// throughput: one chroma sample per cycle while the output does not stall; the last sample of a line holds the input
// while the filter emits the remaining pairs, one per cycle
// reset: window and line position cleared, MPEG-2 mode on, line length 360
`default_nettype none

module chroma_horizontal_upsampler_unit import chu_pkg::*; #(
	parameter int MAX_LINE = 2048
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  chroma_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       even_out,
	output logic [7:0]       odd_out,
	output logic             line_end,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic        mode;
	logic [11:0] line_samples;
	logic        job_valid;
	job_t        job;
	pair_t       pair;
	logic        emit;
	logic        out_v_q;
	pair_t       out_q;

	chu_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.mode         (mode),
		.line_samples (line_samples)
	);

	chu_front #(
		.MAX_LINE (MAX_LINE)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.chroma_in    (chroma_in),
		.line_samples (line_samples),
		.emit         (emit),
		.job_valid    (job_valid),
		.job          (job)
	);

	chu_filter u_filter (
		.mode (mode),
		.job  (job),
		.pair (pair)
	);

	// output register refills in the cycle its transfer completes
	assign emit = job_valid && (!out_v_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (emit)
			out_v_q <= 1'b1;
		else if (!out_stall)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit)
			out_q <= pair;
	end

	assign out_valid = out_v_q;
	assign even_out  = out_q.even;
	assign odd_out   = out_q.odd;
	assign line_end  = out_q.last;

endmodule

`default_nettype wire
